// File: rtl/core/dll_pkg.sv
// Shared types and constants for the doubly linked list engine.
package dll_pkg;

  typedef enum logic [3:0] {
    FUNC_INS_FIRST  = 4'd0,
    FUNC_INS_LAST   = 4'd1,
    FUNC_INS_AFTER  = 4'd2,
    FUNC_INS_BEFORE = 4'd3,
    FUNC_DEL_FIRST  = 4'd4,
    FUNC_DEL_LAST   = 4'd5,
    FUNC_DEL_VALUE  = 4'd6,
    FUNC_FWD        = 4'd7,
    FUNC_BACK       = 4'd8
  } func_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // Which array a datapath write goes to
  typedef enum logic [1:0] {
    WSEL_NONE = 2'd0,
    WSEL_WORD = 2'd1,
    WSEL_NEXT = 2'd2,
    WSEL_PREV = 2'd3
  } wsel_e;

endpackage

// File: rtl/core/dll_ram.sv
// Generic single-write RAM with registered read.
module dll_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/dll_ctrl.sv
// Sequencer for the doubly linked list engine: one memory access per cycle.
module dll_ctrl import dll_pkg::*; #(
  parameter int Capacity = 16,
  parameter int WordWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            func_i,
  input  logic [WordWidth-1:0]  key_w_i,
  input  logic [WordWidth-1:0]  val_w_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WordWidth-1:0]  out_word_o,
  output logic [1:0]            out_status_o,
  output logic                  out_last_o,
  // memory command and status
  output wsel_e                 wsel_o,
  output logic [$clog2(Capacity)-1:0] waddr_o,
  output logic [WordWidth-1:0]  wdata_o,
  output logic [$clog2(Capacity)-1:0] raddr_o,
  input  logic [WordWidth-1:0]  rword_i,
  input  logic [$clog2(Capacity):0] rnext_i,
  input  logic [$clog2(Capacity):0] rprev_i
);

  localparam int AW = $clog2(Capacity);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NIL = PW'(Capacity);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_NEW_WORD, S_NEW_NEXT, S_NEW_PREV, S_FIX_P, S_FIX_Q,
    S_UNLINK_P, S_UNLINK_Q, S_OUT
  } state_e;

  state_e          state_q;
  func_e           func_q;
  logic [WordWidth-1:0] key_q, val_q;
  logic [PW-1:0]   cur_q, head_q, tail_q, p_q, q_q, n_q;
  logic [PW-1:0]   steps_q;
  logic [Capacity-1:0] free_q;
  logic [WordWidth-1:0] oword_q;
  logic [1:0]      ostat_q;
  logic            olast_q, ovalid_q;
  // result of a single-result request, held until the output register is free
  logic [WordWidth-1:0] res_word_q;
  logic [1:0]      res_stat_q;

  // lowest free node
  logic [PW-1:0] alloc;
  always_comb begin
    alloc = NIL;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) alloc = PW'(i);
    end
  end

  logic fwd_dir;
  assign fwd_dir = (func_q == FUNC_FWD);
  logic is_trav, is_search;
  assign is_trav = (func_q == FUNC_FWD) || (func_q == FUNC_BACK);
  assign is_search = (func_q == FUNC_INS_AFTER) || (func_q == FUNC_INS_BEFORE) ||
                     (func_q == FUNC_DEL_VALUE);

  // output register takes a new result
  logic out_load;
  assign out_load = ((state_q == S_OUT) || ((state_q == S_CHK) && is_trav)) &&
                    (!ovalid_q || out_ready_i);

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_word_o   = oword_q;
  assign out_status_o = ostat_q;
  assign out_last_o   = olast_q;
  assign raddr_o      = cur_q[AW-1:0];

  // memory write command
  always_comb begin
    wsel_o  = WSEL_NONE;
    waddr_o = n_q[AW-1:0];
    wdata_o = '0;
    unique case (state_q)
      S_NEW_WORD: begin wsel_o = WSEL_WORD; wdata_o = val_q; end
      S_NEW_NEXT: begin wsel_o = WSEL_NEXT; wdata_o = WordWidth'(q_q); end
      S_NEW_PREV: begin wsel_o = WSEL_PREV; wdata_o = WordWidth'(p_q); end
      S_FIX_P: if (p_q != NIL) begin
        wsel_o = WSEL_NEXT; waddr_o = p_q[AW-1:0]; wdata_o = WordWidth'(n_q);
      end
      S_FIX_Q: if (q_q != NIL) begin
        wsel_o = WSEL_PREV; waddr_o = q_q[AW-1:0]; wdata_o = WordWidth'(n_q);
      end
      S_UNLINK_P: if (p_q != NIL) begin
        wsel_o = WSEL_NEXT; waddr_o = p_q[AW-1:0]; wdata_o = WordWidth'(q_q);
      end
      S_UNLINK_Q: if (q_q != NIL) begin
        wsel_o = WSEL_PREV; waddr_o = q_q[AW-1:0]; wdata_o = WordWidth'(p_q);
      end
      default: ;
    endcase
  end

  logic [WordWidth-1:0] word_out;
  assign word_out = rword_i;

  // state, list registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      func_q   <= FUNC_INS_FIRST;
      head_q   <= NIL;
      tail_q   <= NIL;
      free_q   <= '1;
      ovalid_q <= 1'b0;
      cur_q    <= NIL;
      steps_q  <= '0;
      p_q <= NIL; q_q <= NIL; n_q <= NIL;
      key_q <= '0; val_q <= '0; oword_q <= '0; ostat_q <= '0; olast_q <= 1'b0;
      res_word_q <= '0; res_stat_q <= '0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          key_q <= key_w_i;
          val_q <= val_w_i;
          steps_q <= '0;
          res_word_q <= '0;
          res_stat_q <= STATUS_OK;
          if (func_i <= 4'd8) begin
            func_q <= func_e'(func_i);
            unique case (func_e'(func_i))
              FUNC_INS_FIRST, FUNC_INS_LAST: begin
                if (alloc == NIL) begin
                  res_stat_q <= STATUS_FULL; state_q <= S_OUT;
                end else begin
                  n_q <= alloc;
                  free_q[alloc[AW-1:0]] <= 1'b0;
                  if (func_i == FUNC_INS_FIRST) begin
                    p_q <= NIL; q_q <= head_q;
                  end else begin
                    p_q <= tail_q; q_q <= NIL;
                  end
                  state_q <= S_NEW_WORD;
                end
              end
              FUNC_DEL_FIRST, FUNC_DEL_LAST: begin
                if (head_q == NIL) begin
                  res_word_q <= '1; res_stat_q <= STATUS_EMPTY; state_q <= S_OUT;
                end else begin
                  cur_q <= (func_i == FUNC_DEL_FIRST) ? head_q : tail_q;
                  state_q <= S_RD;
                end
              end
              default: begin
                if (head_q == NIL) begin
                  res_stat_q <= STATUS_EMPTY; state_q <= S_OUT;
                end else begin
                  cur_q <= (func_i == FUNC_BACK) ? tail_q : head_q;
                  state_q <= S_RD;
                end
              end
            endcase
          end
        end
        // read issued at cur_q, data valid next cycle
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (is_trav) begin
            if (out_load) begin
              logic [PW-1:0] nx;
              nx = fwd_dir ? rnext_i : rprev_i;
              oword_q  <= word_out;
              ostat_q  <= STATUS_OK;
              olast_q  <= (nx >= NIL) || (steps_q + 1'b1 >= NIL);
              steps_q  <= steps_q + 1'b1;
              if ((nx >= NIL) || (steps_q + 1'b1 >= NIL)) begin
                state_q <= S_IDLE;
              end else begin
                cur_q <= nx; state_q <= S_RD;
              end
            end
          end else if (is_search) begin
            logic hit;
            hit = (func_q == FUNC_DEL_VALUE) ? (rword_i == val_q) : (rword_i == key_q);
            if (hit) begin
              if (func_q == FUNC_DEL_VALUE) begin
                p_q <= rprev_i; q_q <= rnext_i;
                res_word_q <= word_out; n_q <= cur_q;
                free_q[cur_q[AW-1:0]] <= 1'b1;
                state_q <= S_UNLINK_P;
              end else if (alloc == NIL) begin
                res_stat_q <= STATUS_FULL; state_q <= S_OUT;
              end else begin
                n_q <= alloc;
                free_q[alloc[AW-1:0]] <= 1'b0;
                if (func_q == FUNC_INS_AFTER) begin
                  p_q <= cur_q; q_q <= rnext_i;
                end else begin
                  p_q <= rprev_i; q_q <= cur_q;
                end
                state_q <= S_NEW_WORD;
              end
            end else if ((rnext_i >= NIL) || (steps_q + 1'b1 >= NIL)) begin
              res_stat_q <= STATUS_NOT_FOUND; state_q <= S_OUT;
            end else begin
              steps_q <= steps_q + 1'b1;
              cur_q <= rnext_i; state_q <= S_RD;
            end
          end else begin
            // delete at an end
            p_q <= rprev_i; q_q <= rnext_i; n_q <= cur_q;
            res_word_q <= word_out;
            free_q[cur_q[AW-1:0]] <= 1'b1;
            state_q <= S_UNLINK_P;
          end
        end
        S_NEW_WORD: state_q <= S_NEW_NEXT;
        S_NEW_NEXT: state_q <= S_NEW_PREV;
        S_NEW_PREV: state_q <= S_FIX_P;
        S_FIX_P: begin
          if (p_q == NIL) head_q <= n_q;
          state_q <= S_FIX_Q;
        end
        S_FIX_Q: begin
          if (q_q == NIL) tail_q <= n_q;
          state_q <= S_OUT;
        end
        S_UNLINK_P: begin
          if (p_q == NIL) head_q <= q_q;
          state_q <= S_UNLINK_Q;
        end
        S_UNLINK_Q: begin
          if (q_q == NIL) tail_q <= p_q;
          state_q <= S_OUT;
        end
        S_OUT: if (out_load) begin
          oword_q  <= res_word_q;
          ostat_q  <= res_stat_q;
          olast_q  <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/dll_datapath.sv
// Node pool storage: word, next and prev memories.
module dll_datapath import dll_pkg::*; #(
  parameter int Capacity = 16,
  parameter int WordWidth = 32
) (
  input  logic                        clk_i,
  input  wsel_e                       wsel_i,
  input  logic [$clog2(Capacity)-1:0] waddr_i,
  input  logic [WordWidth-1:0]        wdata_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  output logic [WordWidth-1:0]        rword_o,
  output logic [$clog2(Capacity):0]   rnext_o,
  output logic [$clog2(Capacity):0]   rprev_o
);

  localparam int PW = $clog2(Capacity) + 1;
  logic [PW-1:0] link_wdata;
  assign link_wdata = wdata_i[PW-1:0];

  dll_ram #(.Width(WordWidth), .Depth(Capacity)) u_word (
    .clk_i, .we_i(wsel_i == WSEL_WORD), .waddr_i, .wdata_i,
    .raddr_i, .rdata_o(rword_o)
  );
  dll_ram #(.Width(PW), .Depth(Capacity)) u_next (
    .clk_i, .we_i(wsel_i == WSEL_NEXT), .waddr_i, .wdata_i(link_wdata),
    .raddr_i, .rdata_o(rnext_o)
  );
  dll_ram #(.Width(PW), .Depth(Capacity)) u_prev (
    .clk_i, .we_i(wsel_i == WSEL_PREV), .waddr_i, .wdata_i(link_wdata),
    .raddr_i, .rdata_o(rprev_o)
  );

endmodule

// File: rtl/core/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine.
// Bounded doubly linked list of signed words in a pool of CAPACITY nodes. One
// request is handled at a time. Searches and traversals walk the list node by
// node (registered read of the node memories, then compare), visiting at most
// CAPACITY nodes. A result held off by the receiver stalls the engine only at
// its next result. Traversals give one result per node, last marking the
// final one. No clearing pass is needed after reset.
module doubly_linked_list_engine import dll_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] word_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int AW = $clog2(CAPACITY);

  logic [WORD_WIDTH-1:0] key_w, val_w, oword;
  wsel_e wsel;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_WIDTH-1:0] wdata, rword;
  logic [AW:0] rnext, rprev;

  // word width conversion in and out
  assign key_w  = WORD_WIDTH'(64'(key_i));
  assign val_w  = WORD_WIDTH'(64'(value_i));
  assign word_o = 32'(64'(signed'(oword)));

  dll_ctrl #(.Capacity(CAPACITY), .WordWidth(WORD_WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .key_w_i(key_w), .val_w_i(val_w),
    .out_valid_o, .out_ready_i, .out_word_o(oword), .out_status_o(status_o),
    .out_last_o(last_o),
    .wsel_o(wsel), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr),
    .rword_i(rword), .rnext_i(rnext), .rprev_i(rprev)
  );

  dll_datapath #(.Capacity(CAPACITY), .WordWidth(WORD_WIDTH)) u_dp (
    .clk_i, .wsel_i(wsel), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rword_o(rword), .rnext_o(rnext), .rprev_o(rprev)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the doubly linked list engine.
module testbench;
  import dll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 16;
  localparam int NIL = CAP;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 2 * CAP + 20;
  localparam logic [3:0] FUNC_RSVD_FIRST = 4'd9;
  localparam logic [3:0] FUNC_RSVD_LAST  = 4'd15;

  typedef struct packed {
    logic signed [31:0] word;
    logic [1:0]         status;
    logic               last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         func = FUNC_INS_FIRST;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] word;
  logic [1:0]         status;
  logic               last;

  // Shadow copy of the list
  logic signed [31:0] list_word [CAP];
  int                 list_next [CAP];
  int                 list_prev [CAP];
  logic [CAP-1:0]     free_nodes;
  int                 head, tail;

  result_t expected_results [$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  logic    rx_hold = 1'b0;
  logic signed [31:0] word_pool [8];

  doubly_linked_list_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .key_i(key), .value_i(value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .word_o(word), .status_o(status), .last_o(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[doubly_linked_list_engine] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic signed [31:0] got,
                        input logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    out_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result word", word, 0);
      end else begin
        result_t exp_r;
        exp_r = expected_results.pop_front();
        if (word !== exp_r.word) report("word", word, exp_r.word);
        if (status !== exp_r.status) report("status", 32'(status), 32'(exp_r.status));
        if (last !== exp_r.last) report("last", 32'(last), 32'(exp_r.last));
      end
    end
  end

  function automatic int take_free_node();
    for (int i = 0; i < CAP; i++) begin
      if (free_nodes[i]) begin
        free_nodes[i] = 1'b0;
        return i;
      end
    end
    return NIL;
  endfunction

  function automatic int find_node(input logic signed [31:0] w);
    int c;
    c = head;
    for (int s = 0; s < CAP && c < CAP; s++) begin
      if (list_word[c] == w) return c;
      c = list_next[c];
    end
    return NIL;
  endfunction

  function automatic void link_node(input int n, input int p, input int q,
                                    input logic signed [31:0] w);
    list_word[n] = w;
    list_prev[n] = p;
    list_next[n] = q;
    if (p < CAP) list_next[p] = n; else head = n;
    if (q < CAP) list_prev[q] = n; else tail = n;
  endfunction

  function automatic logic signed [31:0] unlink_node(input int n);
    int p, q;
    p = list_prev[n];
    q = list_next[n];
    if (p < CAP) list_next[p] = q; else head = q;
    if (q < CAP) list_prev[q] = p; else tail = p;
    free_nodes[n] = 1'b1;
    return list_word[n];
  endfunction

  function automatic void push_result(input logic signed [31:0] w, input logic [1:0] st,
                                      input logic lst);
    result_t r;
    r.word = w;
    r.status = st;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // Update the shadow list for one request and queue the results it gives
  function automatic void predict_list_op(input logic [3:0] f, input logic signed [31:0] k,
                                          input logic signed [31:0] v);
    int c, n, nx;
    logic is_empty;
    is_empty = (head >= CAP);
    case (f)
      FUNC_INS_FIRST, FUNC_INS_LAST: begin
        n = take_free_node();
        if (n >= CAP) push_result(0, STATUS_FULL, 1'b1);
        else begin
          if (f == FUNC_INS_FIRST) link_node(n, NIL, head, v);
          else link_node(n, tail, NIL, v);
          push_result(0, STATUS_OK, 1'b1);
        end
      end
      FUNC_INS_AFTER, FUNC_INS_BEFORE: begin
        c = find_node(k);
        if (is_empty) push_result(0, STATUS_EMPTY, 1'b1);
        else if (c >= CAP) push_result(0, STATUS_NOT_FOUND, 1'b1);
        else begin
          n = take_free_node();
          if (n >= CAP) push_result(0, STATUS_FULL, 1'b1);
          else begin
            if (f == FUNC_INS_AFTER) link_node(n, c, list_next[c], v);
            else link_node(n, list_prev[c], c, v);
            push_result(0, STATUS_OK, 1'b1);
          end
        end
      end
      FUNC_DEL_FIRST, FUNC_DEL_LAST: begin
        if (is_empty) push_result(-1, STATUS_EMPTY, 1'b1);
        else push_result(unlink_node(f == FUNC_DEL_FIRST ? head : tail), STATUS_OK, 1'b1);
      end
      FUNC_DEL_VALUE: begin
        c = find_node(v);
        if (is_empty) push_result(0, STATUS_EMPTY, 1'b1);
        else if (c >= CAP) push_result(0, STATUS_NOT_FOUND, 1'b1);
        else push_result(unlink_node(c), STATUS_OK, 1'b1);
      end
      FUNC_FWD, FUNC_BACK: begin
        if (is_empty) push_result(0, STATUS_EMPTY, 1'b1);
        else begin
          c = (f == FUNC_FWD) ? head : tail;
          for (int s = 0; s < CAP && c < CAP; s++) begin
            nx = (f == FUNC_FWD) ? list_next[c] : list_prev[c];
            push_result(list_word[c], STATUS_OK, (nx >= CAP) || (s + 1 >= CAP));
            c = nx;
          end
        end
      end
      default: ;  // reserved codes are ignored
    endcase
  endfunction

  // Send one request; called and returning at a falling edge
  task automatic send_request(input logic [3:0] f, input logic signed [31:0] k,
                              input logic signed [31:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func = f;
    key = k;
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_list_op(f, k, v);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    if ($urandom_range(3) == 0) return $urandom();
    return word_pool[$urandom_range(7)];
  endfunction

  task automatic test_directed();
    send_request(FUNC_FWD, 0, 0);                  // traverse empty list
    send_request(FUNC_BACK, 0, 0);
    send_request(FUNC_DEL_FIRST, 0, 0);            // end deletes on empty list
    send_request(FUNC_DEL_LAST, 0, 0);
    send_request(FUNC_DEL_VALUE, 0, 5);            // delete value on empty list
    send_request(FUNC_INS_AFTER, 1, 2);            // keyed insert on empty list
    send_request(FUNC_INS_BEFORE, 1, 2);
    send_request(FUNC_RSVD_FIRST, 3, 4);           // reserved codes
    send_request(FUNC_RSVD_LAST, 3, 4);
    send_request(FUNC_INS_FIRST, 0, 32'sh7fffffff); // first insert sets head and tail
    send_request(FUNC_INS_LAST, 0, 32'sh80000000);
    send_request(FUNC_INS_FIRST, 0, -1);
    send_request(FUNC_INS_AFTER, -1, 0);
    send_request(FUNC_INS_BEFORE, 32'sh80000000, 7);
    send_request(FUNC_INS_AFTER, 32'sh55aa55aa, 9); // key absent
    send_request(FUNC_INS_BEFORE, 12345, 9);
    send_request(FUNC_FWD, 0, 0);
    send_request(FUNC_BACK, 0, 0);
    send_request(FUNC_DEL_VALUE, 0, 99);           // value absent
    send_request(FUNC_DEL_VALUE, 0, 0);
    send_request(FUNC_DEL_FIRST, 0, 0);
    send_request(FUNC_DEL_LAST, 0, 0);
    send_request(FUNC_FWD, 0, 0);
    drain();
  endtask

  task automatic test_random(input int count);
    int sent, r;
    logic [3:0] f;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 3) f = 4'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
      else if (r < 50) f = 4'($urandom_range(FUNC_INS_FIRST, FUNC_INS_BEFORE));
      else if (r < 82) f = 4'($urandom_range(FUNC_DEL_FIRST, FUNC_DEL_VALUE));
      else f = 4'($urandom_range(FUNC_FWD, FUNC_BACK));
      send_request(f, pick_word(), pick_word());
      if (f < FUNC_RSVD_FIRST) sent++;
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering; also fills the pool
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        for (int i = 0; i < CAP + 3; i++) send_request(FUNC_INS_LAST, 0, pick_word());
        send_request(FUNC_INS_AFTER, list_word[head], 1);
        send_request(FUNC_FWD, 0, 0);
        send_request(FUNC_BACK, 0, 0);
      end
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < CAP; i++) begin
      list_word[i] = '0;
      list_next[i] = NIL;
      list_prev[i] = NIL;
    end
    free_nodes = '1;
    head = NIL;
    tail = NIL;
    word_pool[0] = 0;
    word_pool[1] = -1;
    word_pool[2] = 32'sh7fffffff;
    word_pool[3] = 32'sh80000000;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    send_idle = 11;
    recv_idle = 80;
    test_random(120);
    test_backpressure();
    send_idle = 80;
    recv_idle = 11;
    test_random(110);
    send_idle = 0;
    recv_idle = 0;
    test_random(110);

    if (errors == 0) begin
      $display("[doubly_linked_list_engine] OK");
    end else begin
      $display("[doubly_linked_list_engine] ERROR");
    end
    $finish;
  end

endmodule
